FILE: src/cartesian_to_spherical_top_assert.svh
`ifndef CARTESIAN_TO_SPHERICAL_TOP_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_TOP_ASSERT_SVH
// Assertion helpers shared by the checker.
`define C2S_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) cond) \
        else $error("c2s check failed");
`define C2S_ASSERT_RST(label, cond) \
    label: assert property (@(posedge aclk) cond) \
        else $error("c2s reset check failed");
`endif

FILE: src/c2s_pkg.sv
package c2s_pkg;
    localparam int COORD_BITS   = 24;
    localparam int ANGLE_BITS   = 16;
    localparam int STEPS        = 30;
    localparam int PRESCALE     = 58 - COORD_BITS;
    localparam int CW           = 64;
    localparam int ACC_W        = 33;
    localparam int SUM_W        = 2 * COORD_BITS + 2;
    localparam int ROOT_W       = COORD_BITS + 1;
    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

    typedef logic signed [CW-1:0]    cw_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    function automatic acc_t atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
            27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return acc_t'({1'b0, v});
    endfunction

    // One CORDIC vectoring step toward y = 0.
    typedef struct packed {
        cw_t  x;
        cw_t  y;
        acc_t acc;
    } vec_t;

    function automatic vec_t cordic_step(input vec_t v, input int i);
        vec_t r;
        cw_t  dx;
        cw_t  dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        r  = v;
        if (!v.y[CW-1]) begin
            r.x = v.x + dx; r.y = v.y - dy; r.acc = v.acc + atan_tab(i);
        end else begin
            r.x = v.x - dx; r.y = v.y + dy; r.acc = v.acc - atan_tab(i);
        end
        return r;
    endfunction

    function automatic logic signed [ANGLE_BITS+1:0] to_angle(input acc_t a);
        acc_t t;
        t = (a + (acc_t'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        return t[ANGLE_BITS+1:0];
    endfunction
endpackage

FILE: src/c2s_sqrt.sv
// Pipelined restoring square root, one result bit per stage, then round.
module c2s_sqrt (
    input  logic                           aclk,
    input  logic                           adv,
    input  logic [c2s_pkg::SUM_W-1:0]      sum_in,
    output logic [c2s_pkg::ROOT_W-1:0]     root_out
);
    import c2s_pkg::*;
    localparam int NS = ROOT_W;
    localparam int RW = SUM_W + 2;

    logic [SUM_W-1:0]  val_reg  [NS+1];
    logic [RW-1:0]     rem_reg  [NS+1];
    logic [ROOT_W-1:0] root_reg [NS+1];

    assign val_reg[0]  = sum_in;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RW-1:0]     shifted;
        logic [RW-1:0]     trial;
        always_comb begin
            shifted = {rem_reg[k][RW-3:0], val_reg[k][SUM_W-1 -: 2]};
            trial   = RW'({root_reg[k], 2'b01});
            if (shifted >= trial) begin
                rem_next  = shifted - trial;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
        logic [SUM_W-1:0]  v_reg;
        logic [RW-1:0]     r_reg;
        logic [ROOT_W-1:0] o_reg;
        always_ff @(posedge aclk) begin
            if (adv) begin
                v_reg <= val_reg[k] << 2;
                r_reg <= rem_next;
                o_reg <= root_next;
            end
        end
        assign val_reg[k+1]  = v_reg;
        assign rem_reg[k+1]  = r_reg;
        assign root_reg[k+1] = o_reg;
    end

    // remainder > root means s > r*r + r
    assign root_out = root_reg[NS] +
        ROOT_W'(rem_reg[NS] > RW'(root_reg[NS]));
endmodule

FILE: src/cartesian_to_spherical_top.sv
// Channel | Ports                                  | Direction
// input   | s_valid s_ready s_coord_x/y/z          | in
// result  | m_valid m_ready m_length m_azimuth ... | out
// Pipeline: 62 register stages (prep, 30 azimuth steps, 30 polar steps, out).
// Gain multiply and square root run beside the CORDIC chains.
// Throughput: one transaction per cycle while no stall at m_ready holds the pipe.
// Reset clears valid bits only. A stall at m_ready holds the entire pipe.
module cartesian_to_spherical_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [c2s_pkg::COORD_BITS-1:0]   s_coord_x,
    input  logic signed [c2s_pkg::COORD_BITS-1:0]   s_coord_y,
    input  logic signed [c2s_pkg::COORD_BITS-1:0]   s_coord_z,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [c2s_pkg::COORD_BITS-1:0]          m_length,
    output logic signed [c2s_pkg::ANGLE_BITS-1:0]   m_azimuth,
    output logic [c2s_pkg::ANGLE_BITS-1:0]          m_polar_angle,
    output logic signed [c2s_pkg::ANGLE_BITS-1:0]   m_elevation,
    output logic                                    m_azimuth_undefined,
    output logic                                    m_polar_undefined
);
    import c2s_pkg::*;
    localparam int DEPTH = 2 * STEPS + 2;
    localparam int SQ_LAT = ROOT_W + 1;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int HALF = 1 << (ANGLE_BITS - 1);

    typedef struct packed {
        logic az_undef;
        logic pol_undef;
        logic x_zero;
        logic y_pos;
        logic y_neg;
    } flags_t;

    logic            adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    // stage 0: scale, fold x >= 0, sum of squares, flags
    logic [COORD_BITS-1:0] ax, ay, az_m;
    assign ax   = s_coord_x[COORD_BITS-1] ? COORD_BITS'(-s_coord_x) : s_coord_x;
    assign ay   = s_coord_y[COORD_BITS-1] ? COORD_BITS'(-s_coord_y) : s_coord_y;
    assign az_m = s_coord_z[COORD_BITS-1] ? COORD_BITS'(-s_coord_z) : s_coord_z;

    cw_t xs, ys;
    assign xs = cw_t'(s_coord_x);
    assign ys = cw_t'(s_coord_y);

    logic [SUM_W-1:0] sq_sum_reg;
    vec_t   v0_reg;
    cw_t    z0_reg;
    flags_t f0_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_sum_reg <= SUM_W'(ax) * SUM_W'(ax) + SUM_W'(ay) * SUM_W'(ay) +
                          SUM_W'(az_m) * SUM_W'(az_m);
            v0_reg.x   <= (s_coord_x[COORD_BITS-1] ? -xs : xs) <<< PRESCALE;
            v0_reg.y   <= (s_coord_x[COORD_BITS-1] ? -ys : ys) <<< PRESCALE;
            v0_reg.acc <= '0;
            z0_reg     <= cw_t'(s_coord_z) <<< PRESCALE;
            f0_reg.az_undef  <= (s_coord_x == '0) && (s_coord_y == '0);
            f0_reg.pol_undef <= (s_coord_x == '0) && (s_coord_y == '0) && (s_coord_z == '0);
            f0_reg.x_zero    <= (s_coord_x == '0);
            f0_reg.y_pos     <= !s_coord_y[COORD_BITS-1] && (s_coord_y != '0);
            f0_reg.y_neg     <= s_coord_y[COORD_BITS-1];
        end
    end

    logic [ROOT_W-1:0] root;
    c2s_sqrt u_sqrt (.aclk(aclk), .adv(adv), .sum_in(sq_sum_reg), .root_out(root));

    // azimuth CORDIC, one step per stage
    vec_t   av_reg [STEPS+1];
    assign av_reg[0] = v0_reg;
    for (genvar i = 0; i < STEPS; i++) begin : g_az
        vec_t st_reg;
        always_ff @(posedge aclk) if (adv) st_reg <= cordic_step(av_reg[i], i);
        assign av_reg[i+1] = st_reg;
    end

    // gain multiply on |z| over two stages, in parallel with azimuth steps
    logic [CW-1:0] uz;
    assign uz = z0_reg[CW-1] ? CW'(-z0_reg) : CW'(z0_reg);
    logic [63:0] mh_reg, ml_reg;
    logic        zs1_reg;
    cw_t         zk2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            mh_reg  <= 64'(uz[57:31]) * 64'(GAIN_Q30);
            ml_reg  <= 64'(uz[30:0]) * 64'(GAIN_Q30);
            zs1_reg <= z0_reg[CW-1];
            zk2_reg <= zs1_reg ? -cw_t'((mh_reg << 1) + (ml_reg >> 30))
                               :  cw_t'((mh_reg << 1) + (ml_reg >> 30));
        end
    end
    // delay zk to meet end of azimuth chain
    localparam int ZD = STEPS - 2;
    cw_t zd_reg [ZD];
    always_ff @(posedge aclk) begin
        if (adv) begin
            zd_reg[0] <= zk2_reg;
            for (int k = 1; k < ZD; k++) zd_reg[k] <= zd_reg[k-1];
        end
    end

    flags_t fd_reg [DEPTH-2];
    always_ff @(posedge aclk) begin
        if (adv) begin
            fd_reg[0] <= f0_reg;
            for (int k = 1; k < DEPTH - 2; k++) fd_reg[k] <= fd_reg[k-1];
        end
    end

    // azimuth result and polar setup
    cw_t  zk;
    vec_t pv0;
    assign zk = zd_reg[ZD-1];
    always_comb begin
        if (zk[CW-1]) begin
            pv0.x = av_reg[STEPS].x; pv0.y = -zk; pv0.acc = acc_t'(33'sh40000000);
        end else begin
            pv0.x = zk; pv0.y = av_reg[STEPS].x; pv0.acc = '0;
        end
    end
    logic signed [ANGLE_BITS+1:0] azr;
    assign azr = to_angle(av_reg[STEPS].acc);
    logic signed [ANGLE_BITS-1:0] azd_reg [STEPS];
    logic signed [ANGLE_BITS-1:0] az_next;
    always_comb begin
        if (azr > QUARTER)       az_next = ANGLE_BITS'(QUARTER);
        else if (azr < -QUARTER) az_next = ANGLE_BITS'(-QUARTER);
        else                     az_next = azr[ANGLE_BITS-1:0];
    end
    // align azimuth with the end of the polar chain
    always_ff @(posedge aclk) begin
        if (adv) begin
            azd_reg[0] <= az_next;
            for (int k = 1; k < STEPS; k++) azd_reg[k] <= azd_reg[k-1];
        end
    end

    vec_t pv_reg [STEPS+1];
    for (genvar i = 0; i < STEPS; i++) begin : g_pol
        vec_t st_reg;
        always_ff @(posedge aclk) if (adv) st_reg <= cordic_step(pv_reg[i], i);
        assign pv_reg[i+1] = st_reg;
    end
    assign pv_reg[0] = pv0;

    // root delay to output
    localparam int RD = DEPTH - 1 - SQ_LAT;
    logic [ROOT_W-1:0] rd_reg [RD];
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg[0] <= root;
            for (int k = 1; k < RD; k++) rd_reg[k] <= rd_reg[k-1];
        end
    end

    // output stage
    flags_t fo;
    assign fo = fd_reg[DEPTH-3];
    logic signed [ANGLE_BITS+1:0] pr;
    assign pr = to_angle(pv_reg[STEPS].acc);
    logic [ANGLE_BITS-1:0] pol_next;
    always_comb begin
        if (fo.pol_undef)  pol_next = '0;
        else if (pr < 0)   pol_next = '0;
        else if (pr > HALF) pol_next = ANGLE_BITS'(HALF);
        else               pol_next = pr[ANGLE_BITS-1:0];
    end
    logic signed [ANGLE_BITS-1:0] azo;
    always_comb begin
        if (fo.x_zero)
            azo = fo.y_pos ? ANGLE_BITS'(QUARTER) :
                  (fo.y_neg ? ANGLE_BITS'(-QUARTER) : '0);
        else azo = azd_reg[STEPS-1];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_length            <= rd_reg[RD-1][COORD_BITS-1:0];
            m_azimuth           <= azo;
            m_polar_angle       <= pol_next;
            m_elevation         <= ANGLE_BITS'(QUARTER) - pol_next;
            m_azimuth_undefined <= fo.az_undef;
            m_polar_undefined   <= fo.pol_undef;
        end
    end
endmodule

FILE: src/c2s_checker.sv
`include "cartesian_to_spherical_top_assert.svh"
module c2s_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [c2s_pkg::COORD_BITS-1:0]        m_length,
    input logic [c2s_pkg::ANGLE_BITS-1:0]        m_polar_angle,
    input logic [c2s_pkg::ANGLE_BITS-1:0]        m_elevation,
    input logic                                  m_azimuth_undefined,
    input logic                                  m_polar_undefined
);
    import c2s_pkg::*;
    `C2S_ASSERT_RST(a_rst_idle, !aresetn |=> !m_valid)
    `C2S_ASSERT(a_ready_free, !m_valid |-> s_ready)
    `C2S_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_length))
    `C2S_ASSERT(a_pol_zero, m_valid && m_polar_undefined |-> m_azimuth_undefined && m_length == '0)
    `C2S_ASSERT(a_elev, m_valid |-> ANGLE_BITS'(m_polar_angle + m_elevation) == ANGLE_BITS'(1 << (ANGLE_BITS - 2)))
endmodule

bind cartesian_to_spherical_top c2s_checker u_chk (.*);

FILE: dv/tb_cartesian_to_spherical_top.sv
`timescale 1ns / 1ps

module tb_cartesian_to_spherical_top;
    import c2s_pkg::*;

    localparam int LATENCY = 64;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int HALF    = 1 << (ANGLE_BITS - 1);
    localparam logic [63:0] GAIN = 64'd1768195363;

    typedef struct packed {
        logic [COORD_BITS-1:0]        length;
        logic signed [ANGLE_BITS-1:0] azimuth;
        logic [ANGLE_BITS-1:0]        polar_angle;
        logic signed [ANGLE_BITS-1:0] elevation;
        logic                         azimuth_undefined;
        logic                         polar_undefined;
    } sph_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [COORD_BITS-1:0] s_coord_x;
    logic signed [COORD_BITS-1:0] s_coord_y;
    logic signed [COORD_BITS-1:0] s_coord_z;
    logic m_valid;
    logic m_ready;
    logic [COORD_BITS-1:0]        m_length;
    logic signed [ANGLE_BITS-1:0] m_azimuth;
    logic [ANGLE_BITS-1:0]        m_polar_angle;
    logic signed [ANGLE_BITS-1:0] m_elevation;
    logic m_azimuth_undefined;
    logic m_polar_undefined;

    sph_t expected_sph_q[$];
    int   n_sent;
    int   n_checked;
    int   n_mismatch;
    bit   stall_enable;

    cartesian_to_spherical_top i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint atan_entry(input int i);
        logic [32:0] v;
        v = atan_tab(i);
        return longint'(v);
    endfunction

    // Vector (x,y) onto the x axis; return accumulated angle, 2^32 per turn.
    function automatic longint rotate_to_axis(inout longint vx, inout longint vy);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += atan_entry(i);
            end else begin
                vx -= dx; vy += dy; acc -= atan_entry(i);
            end
        end
        return acc;
    endfunction

    function automatic longint binary_angle(input longint acc);
        return (acc + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
    endfunction

    function automatic longint apply_gain(input longint v);
        logic [63:0] u;
        logic [63:0] m;
        u = v < 0 ? -v : v;
        m = (u >> 31) * GAIN * 2 + (((u & 64'h7FFF_FFFF) * GAIN) >> 30);
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic sph_t convert_vector(input longint x, input longint y,
                                            input longint z);
        sph_t r;
        logic [99:0] sum;
        logic [99:0] sq;
        logic [49:0] root;
        logic [49:0] cand;
        longint scale;
        longint cx;
        longint cy;
        longint zk;
        longint px;
        longint py;
        longint base;
        longint az;
        longint pol;
        sum = 100'(x * x) + 100'(y * y) + 100'(z * z);
        root = 0;
        for (int b = 49; b >= 0; b--) begin
            cand = root | (50'd1 << b);
            sq = 100'(cand) * 100'(cand);
            if (sq <= sum) root = cand;
        end
        if (sum > 100'(root) * 100'(root) + 100'(root)) root++;
        scale = longint'(1) << PRESCALE;
        cx = x * scale;
        cy = y * scale;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
        end
        az = binary_angle(rotate_to_axis(cx, cy));
        if (az < -QUARTER) az = -QUARTER;
        if (az > QUARTER) az = QUARTER;
        if (x == 0) az = y > 0 ? QUARTER : (y < 0 ? -QUARTER : 0);
        zk = apply_gain(z * scale);
        if (zk < 0) begin
            px = cx; py = -zk; base = longint'(1) << 30;
        end else begin
            px = zk; py = cx; base = 0;
        end
        pol = binary_angle(base + rotate_to_axis(px, py));
        if (pol < 0) pol = 0;
        if (pol > HALF) pol = HALF;
        r.azimuth_undefined = (x == 0 && y == 0);
        r.polar_undefined   = r.azimuth_undefined && z == 0;
        if (r.polar_undefined) pol = 0;
        r.length      = root[COORD_BITS-1:0];
        r.azimuth     = az[ANGLE_BITS-1:0];
        r.polar_angle = pol[ANGLE_BITS-1:0];
        r.elevation   = ANGLE_BITS'(QUARTER - pol);
        return r;
    endfunction

    // Drop valid only when idling, so back-to-back transactions see one update.
    task automatic send_vector(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y,
                               input logic signed [COORD_BITS-1:0] z);
        int gap;
        gap = stall_enable ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        expected_sph_q.push_back(convert_vector(x, y, z));
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // Randomly hold off the result side, redrawing after each transaction.
    initial begin
        int hold;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            hold = stall_enable ? $urandom_range(0, 13) : 0;
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        sph_t got;
        sph_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_length, m_azimuth, m_polar_angle, m_elevation,
                    m_azimuth_undefined, m_polar_undefined};
            if (expected_sph_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected transaction: %p", got);
            end else begin
                want = expected_sph_q.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int mode);
        case (mode)
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($signed($urandom_range(0, 200)) - 100);
            2: return 0;
            default: return COORD_BITS'($urandom) >>> $urandom_range(0, 22);
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [COORD_BITS-1:0] mx;
        logic signed [COORD_BITS-1:0] mn;
        mx = {1'b0, {(COORD_BITS-1){1'b1}}};
        mn = {1'b1, {(COORD_BITS-1){1'b0}}};
        send_vector(0, 0, 0);
        send_vector(mx, mx, mx);
        send_vector(mn, mn, mn);
        send_vector(mx, mn, mx);
        send_vector(mn, mx, mn);
        send_vector(-1, -1, -1);
        send_vector(1, 1, 1);
        send_vector(mx, 0, 0);
        send_vector(mn, 0, 0);
    endtask

    task automatic test_axes_and_flags();
        send_vector(0, 5, 0);
        send_vector(0, -5, 3);
        send_vector(0, 0, 7);
        send_vector(0, 0, -7);
        send_vector(-3, 4, 0);
        send_vector(3, -4, 12);
        send_vector(-100, -100, 0);
        send_vector(1, 0, -1);
        send_vector(-1, 1, 1);
        send_vector(0, 1, 0);
        send_vector(0, -1, 0);
        send_vector(7, 7, -1);
    endtask

    task automatic test_random_vectors(input int count);
        int mx;
        int my;
        int mz;
        for (int i = 0; i < count; i++) begin
            stall_enable = (i % 150) >= 30;
            mx = $urandom_range(0, 3);
            my = $urandom_range(0, 3);
            mz = $urandom_range(0, 3);
            send_vector(rand_coord(mx), rand_coord(my), rand_coord(mz));
        end
    endtask

    initial begin
        int drain;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_coord_x = '0;
        s_coord_y = '0;
        s_coord_z = '0;
        stall_enable = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_axes_and_flags();
        test_random_vectors(480);
        s_valid <= 1'b0;
        drain = 0;
        while (expected_sph_q.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (LATENCY + 20) @(posedge aclk);
        $display("sent %0d vectors, checked %0d results, %0d mismatches",
                 n_sent, n_checked, n_mismatch);
        $display("covered zero vector, axis cases, full-scale corners, random stalls");
        if (n_mismatch == 0 && expected_sph_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/c2s_pkg.sv
src/c2s_sqrt.sv
src/cartesian_to_spherical_top.sv
src/c2s_checker.sv
dv/tb_cartesian_to_spherical_top.sv
